// ----- sv/drip_rate_clamp_and_alarm_step_top_assert.svh -----
// Assertion macros for the drip-rate clamp and alarm RTL.
`ifndef DRIP_RATE_CLAMP_AND_ALARM_STEP_TOP_ASSERT_SVH
`define DRIP_RATE_CLAMP_AND_ALARM_STEP_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define DRCA_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define DRCA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- sv/drca_pkg.sv -----
// Types and constants for the drip-rate clamp and alarm block.
`default_nettype none

package drca_pkg;

  localparam int unsigned RateW = 12;
  localparam int unsigned PctW = 7;
  localparam int unsigned FreqW = 12;
  localparam int unsigned LedW = 8;
  localparam int unsigned ProdW = 19;

  localparam logic [PctW-1:0] OpenReset = 7'd30;
  localparam logic [PctW-1:0] OpenMax = 7'd100;
  localparam logic [PctW-1:0] ThreshReset = 7'd30;
  localparam logic [PctW-1:0] VolFault = 7'd100;
  localparam logic [PctW-1:0] VolDev = 7'd60;
  localparam logic [PctW-1:0] VolOff = 7'd0;
  localparam logic [FreqW-1:0] FreqFault = 12'd2500;
  localparam logic [FreqW-1:0] FreqDev = 12'd1500;
  localparam logic [FreqW-1:0] FreqNorm = 12'd1000;
  localparam logic [LedW-1:0] LedFault = 8'd100;
  localparam logic [LedW-1:0] LedMax = 8'd255;
  localparam logic [ProdW-1:0] PctScale = 19'd100;

  localparam int unsigned InDataW = 32;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [1:0] {
    TIER_NORMAL = 2'd0,
    TIER_DEV    = 2'd1,
    TIER_FAULT  = 2'd2
  } drca_tier_e;

  // Fields from the lowest bit up: measured_rate, target_rate, flow_stalled,
  // temp_valid, button_level.
  typedef struct packed {
    logic             button_level;
    logic             temp_valid;
    logic             flow_stalled;
    logic [RateW-1:0] target_rate;
    logic [RateW-1:0] measured_rate;
  } drca_in_t;

  // Fields from the lowest bit up: clamp_open_pct, alarm_tier, buzzer_freq_hz,
  // buzzer_volume, led_level.
  typedef struct packed {
    logic [LedW-1:0]  led_level;
    logic [PctW-1:0]  buzzer_volume;
    logic [FreqW-1:0] buzzer_freq_hz;
    drca_tier_e       alarm_tier;
    logic [PctW-1:0]  clamp_open_pct;
  } drca_out_t;

  typedef struct packed {
    logic [PctW-1:0] open_pct;
    logic            silence;
    logic            button_prev;
  } drca_state_t;

endpackage

`default_nettype wire

// ----- sv/drca_calc.sv -----
// Per-tick clamp step, alarm choice, LED scaling and silence update.
`default_nettype none

module drca_calc #(
  parameter int unsigned RateFracBits = 4
) (
  input  drca_pkg::drca_in_t            item_i,
  input  drca_pkg::drca_state_t         state_i,
  input  logic [drca_pkg::PctW-1:0]     thresh_i,
  output drca_pkg::drca_out_t           result_o,
  output drca_pkg::drca_state_t         state_o
);

  localparam int unsigned LedShift = RateFracBits + 2;
  localparam int unsigned Led5W = drca_pkg::RateW + 3;

  logic                          fault;
  logic                          up;
  logic                          down;
  logic [drca_pkg::PctW-1:0]     open_lim;
  logic [drca_pkg::RateW-1:0]    diff;
  logic [drca_pkg::ProdW-1:0]    diff_scaled;
  logic [drca_pkg::ProdW-1:0]    thresh_scaled;
  logic                          dev;
  logic [Led5W-1:0]              rate_x5;
  logic [Led5W-1:0]              led_wide;
  logic [drca_pkg::LedW-1:0]     rate_led;

  assign fault = item_i.flow_stalled || !item_i.temp_valid;
  assign up = item_i.target_rate > item_i.measured_rate;
  assign down = item_i.target_rate < item_i.measured_rate;
  assign open_lim = (state_i.open_pct > drca_pkg::OpenMax) ? drca_pkg::OpenMax
                                                           : state_i.open_pct;

  assign diff = up ? (item_i.target_rate - item_i.measured_rate)
                   : (item_i.measured_rate - item_i.target_rate);
  assign diff_scaled = drca_pkg::ProdW'(diff) * drca_pkg::PctScale;
  assign thresh_scaled = drca_pkg::ProdW'(thresh_i) * drca_pkg::ProdW'(item_i.target_rate);
  assign dev = (item_i.target_rate != '0) && (diff_scaled > thresh_scaled);

  // Rate times 100/80 is rate times 5/4, and the fraction bits fold into the shift.
  assign rate_x5 = {1'b0, item_i.measured_rate, 2'b00} + Led5W'(item_i.measured_rate);
  assign led_wide = rate_x5 >> LedShift;
  assign rate_led = (led_wide > Led5W'(drca_pkg::LedMax)) ? drca_pkg::LedMax
                                                          : led_wide[drca_pkg::LedW-1:0];

  always_comb begin
    state_o.open_pct = state_i.open_pct;
    if (fault) begin
      state_o.open_pct = '0;
    end else if (up) begin
      state_o.open_pct = (state_i.open_pct < drca_pkg::OpenMax) ?
                         state_i.open_pct + 7'd1 : drca_pkg::OpenMax;
    end else if (down) begin
      state_o.open_pct = (open_lim > '0) ? open_lim - 7'd1 : open_lim;
    end
    state_o.silence = (item_i.button_level && !state_i.button_prev) ?
                      !state_i.silence : state_i.silence;
    state_o.button_prev = item_i.button_level;
  end

  always_comb begin
    result_o.clamp_open_pct = state_o.open_pct;
    if (fault) begin
      result_o.alarm_tier = drca_pkg::TIER_FAULT;
      result_o.buzzer_freq_hz = drca_pkg::FreqFault;
      result_o.buzzer_volume = state_i.silence ? drca_pkg::VolOff : drca_pkg::VolFault;
      result_o.led_level = drca_pkg::LedFault;
    end else if (dev) begin
      result_o.alarm_tier = drca_pkg::TIER_DEV;
      result_o.buzzer_freq_hz = drca_pkg::FreqDev;
      result_o.buzzer_volume = state_i.silence ? drca_pkg::VolOff : drca_pkg::VolDev;
      result_o.led_level = rate_led;
    end else begin
      result_o.alarm_tier = drca_pkg::TIER_NORMAL;
      result_o.buzzer_freq_hz = drca_pkg::FreqNorm;
      result_o.buzzer_volume = drca_pkg::VolOff;
      result_o.led_level = rate_led;
    end
  end

endmodule

`default_nettype wire

// ----- sv/drip_rate_clamp_and_alarm_step_top.sv -----
// Top level of the drip-rate clamp controller and tiered alarm.
//
//   Channel   Direction  Width  Content
//   s_axis    in         32     one control tick per transaction
//   m_axis    out        40     one result per tick
//   cfg       in         7      deviation threshold in percent
//
// A tick is registered on input, computed combinationally and moved into the
// result register while m_axis can take it; that register drives m_axis.
// One transaction per cycle is sustained; the input and result registers form
// a two-deep pipeline that stalls only when m_axis_tready_i is low with both full.
// Reset sets the clamp to 30 percent, the threshold to 30 and clears silence.
`default_nettype none

module drip_rate_clamp_and_alarm_step_top #(
  parameter int unsigned RateFracBits = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // measured_rate, target_rate, flow_stalled, temp_valid, button_level, pad
  input  logic [drca_pkg::InDataW-1:0]       s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // clamp_open_pct, alarm_tier, buzzer_freq_hz, buzzer_volume, led_level, pad
  output logic [drca_pkg::OutDataW-1:0]      m_axis_tdata_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [drca_pkg::PctW-1:0]          cfg_data_i
);

  localparam int unsigned InW = $bits(drca_pkg::drca_in_t);
  localparam int unsigned OutW = $bits(drca_pkg::drca_out_t);

  logic                       in_valid_q;
  drca_pkg::drca_in_t         in_q;
  logic                       out_valid_q;
  drca_pkg::drca_out_t        out_q;
  drca_pkg::drca_out_t        out_d;
  drca_pkg::drca_state_t      state_q;
  drca_pkg::drca_state_t      state_d;
  logic [drca_pkg::PctW-1:0]  thresh_q;
  logic                       out_free;
  logic                       adv;
  logic                       take;
  logic                       out_fault;
  logic                       out_closed;
  logic                       press_seen;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign adv = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign take = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o = 1'b1;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o = {(drca_pkg::OutDataW - OutW)'(0), out_q};

  drca_calc #(
    .RateFracBits(RateFracBits)
  ) u_calc (
    .item_i  (in_q),
    .state_i (state_q),
    .thresh_i(thresh_q),
    .result_o(out_d),
    .state_o (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      state_q.open_pct <= drca_pkg::OpenReset;
      state_q.silence <= 1'b0;
      state_q.button_prev <= 1'b0;
      thresh_q <= drca_pkg::ThreshReset;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (adv) begin
        state_q <= state_d;
      end
      if (cfg_valid_i) begin
        thresh_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= drca_pkg::drca_in_t'(s_axis_tdata_i[InW-1:0]);
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_fault = out_valid_q && (out_q.alarm_tier == drca_pkg::TIER_FAULT);
  assign out_closed = (out_q.clamp_open_pct == '0) && (out_q.led_level == drca_pkg::LedFault);
  assign press_seen = adv && in_q.button_level && !state_q.button_prev;

`include "drip_rate_clamp_and_alarm_step_top_assert.svh"

  `DRCA_ASSERT_NOW(a_open_in_range, 1'b1, state_q.open_pct <= drca_pkg::OpenMax, "open above max")
  `DRCA_ASSERT_NOW(a_fault_closes, out_fault, out_closed, "fault result without closed clamp")
  `DRCA_ASSERT_NEXT(a_silence, press_seen, state_q.silence != $past(state_q.silence), "no toggle")

endmodule

`default_nettype wire

// ----- tb/tb_drip_rate_clamp_and_alarm_step_top.sv -----
// Self-checking testbench for the drip-rate clamp controller and tiered alarm.

module tb_drip_rate_clamp_and_alarm_step_top;

  localparam int unsigned RateFrac = 4;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned MaxPrinted = 20;

  localparam int DirEqual = 0;
  localparam int DirOpen = 1;
  localparam int DirClose = 2;

  class drip_scoreboard;
    drca_pkg::drca_out_t       expected_q[$];
    logic [drca_pkg::PctW-1:0] open_pct;
    logic [drca_pkg::PctW-1:0] threshold;
    bit                        silenced;
    bit                        btn_prev;
    int unsigned               errors;
    int unsigned               ticks;
    int unsigned               faults;
    int unsigned               deviations;
    int unsigned               at_full_open;
    int unsigned               silenced_alarms;

    function new();
      open_pct = drca_pkg::OpenReset;
      threshold = drca_pkg::ThreshReset;
      silenced = 1'b0;
      btn_prev = 1'b0;
      errors = 0;
      ticks = 0;
      faults = 0;
      deviations = 0;
      at_full_open = 0;
      silenced_alarms = 0;
    endfunction

    function void set_threshold(logic [drca_pkg::PctW-1:0] value);
      threshold = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Works out the result of one accepted tick and advances the state.
    function void note_tick(drca_pkg::drca_in_t t);
      int unsigned         meas;
      int unsigned         targ;
      int unsigned         diff;
      int unsigned         led;
      bit                  fault;
      bit                  dev;
      drca_pkg::drca_out_t res;
      meas = t.measured_rate;
      targ = t.target_rate;
      fault = t.flow_stalled || !t.temp_valid;
      if (fault) begin
        open_pct = '0;
      end else if (targ > meas) begin
        if (open_pct < drca_pkg::OpenMax) open_pct = open_pct + 1'b1;
        else open_pct = drca_pkg::OpenMax;
      end else if (targ < meas) begin
        if (open_pct > drca_pkg::OpenMax) open_pct = drca_pkg::OpenMax;
        if (open_pct > 0) open_pct = open_pct - 1'b1;
      end
      diff = (targ > meas) ? targ - meas : meas - targ;
      dev = (targ > 0) && (diff * 100 > int'(threshold) * targ);
      led = (meas * 100) / (80 << RateFrac);
      if (led > drca_pkg::LedMax) led = drca_pkg::LedMax;
      res.clamp_open_pct = open_pct;
      if (fault) begin
        res.alarm_tier = drca_pkg::TIER_FAULT;
        res.buzzer_freq_hz = drca_pkg::FreqFault;
        res.buzzer_volume = silenced ? drca_pkg::VolOff : drca_pkg::VolFault;
        res.led_level = drca_pkg::LedFault;
        faults++;
      end else if (dev) begin
        res.alarm_tier = drca_pkg::TIER_DEV;
        res.buzzer_freq_hz = drca_pkg::FreqDev;
        res.buzzer_volume = silenced ? drca_pkg::VolOff : drca_pkg::VolDev;
        res.led_level = led[drca_pkg::LedW-1:0];
        deviations++;
      end else begin
        res.alarm_tier = drca_pkg::TIER_NORMAL;
        res.buzzer_freq_hz = drca_pkg::FreqNorm;
        res.buzzer_volume = drca_pkg::VolOff;
        res.led_level = led[drca_pkg::LedW-1:0];
      end
      if ((fault || dev) && silenced) silenced_alarms++;
      if (open_pct == drca_pkg::OpenMax) at_full_open++;
      if (t.button_level && !btn_prev) silenced = !silenced;
      btn_prev = t.button_level;
      ticks++;
      expected_q.push_back(res);
    endfunction

    function void report(string field, int unsigned exp_v, int unsigned act_v);
      errors++;
      if (errors <= MaxPrinted)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
    endfunction

    function void check_result(logic [drca_pkg::OutDataW-1:0] raw);
      drca_pkg::drca_out_t got;
      drca_pkg::drca_out_t exp_r;
      got = drca_pkg::drca_out_t'(raw[$bits(drca_pkg::drca_out_t)-1:0]);
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MaxPrinted)
          $display("%0t: result with no tick pending, expected none, actual %h", $time, raw);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.clamp_open_pct !== exp_r.clamp_open_pct)
        report("clamp_open_pct", exp_r.clamp_open_pct, got.clamp_open_pct);
      if (got.alarm_tier !== exp_r.alarm_tier)
        report("alarm_tier", exp_r.alarm_tier, got.alarm_tier);
      if (got.buzzer_freq_hz !== exp_r.buzzer_freq_hz)
        report("buzzer_freq_hz", exp_r.buzzer_freq_hz, got.buzzer_freq_hz);
      if (got.buzzer_volume !== exp_r.buzzer_volume)
        report("buzzer_volume", exp_r.buzzer_volume, got.buzzer_volume);
      if (got.led_level !== exp_r.led_level)
        report("led_level", exp_r.led_level, got.led_level);
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni = 1'b0;
  logic                          s_valid = 1'b0;
  logic [drca_pkg::InDataW-1:0]  s_data = '0;
  logic                          m_ready = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic [drca_pkg::PctW-1:0]     cfg_data = '0;
  logic                          s_axis_tready_o;
  logic                          m_axis_tvalid_o;
  logic [drca_pkg::OutDataW-1:0] m_axis_tdata_o;
  logic                          cfg_ready_o;

  drip_scoreboard sb = new();
  bit             quiet = 1'b0;
  bit             btn_level = 1'b0;
  int unsigned    idle_cycles = 0;
  int unsigned    settings_used = 0;

  drip_rate_clamp_and_alarm_step_top #(
    .RateFracBits(RateFrac)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic drca_pkg::drca_in_t make_tick(int unsigned meas, int unsigned targ,
                                                   bit stall, bit temp_ok, bit btn);
    drca_pkg::drca_in_t t;
    t.measured_rate = meas[drca_pkg::RateW-1:0];
    t.target_rate = targ[drca_pkg::RateW-1:0];
    t.flow_stalled = stall;
    t.temp_valid = temp_ok;
    t.button_level = btn;
    return t;
  endfunction

  // Measured rate is placed around the target so that a run keeps steering
  // the clamp the same way; a share of ticks is unrelated noise.
  function automatic drca_pkg::drca_in_t random_tick(int dir, int unsigned fault_pct);
    int unsigned targ;
    int unsigned meas;
    int unsigned off;
    int unsigned r;
    bit          stall;
    bit          temp_ok;
    r = $urandom_range(0, 9);
    if (r == 0) targ = 0;
    else if (r < 3) targ = $urandom_range(1, 64);
    else targ = $urandom_range(0, 4095);
    off = $urandom_range(0, targ / 2 + 4);
    if ($urandom_range(0, 9) < 2) meas = $urandom_range(0, 4095);
    else if (dir == DirEqual) meas = targ;
    else if (dir == DirOpen) meas = (targ > off) ? targ - off : 0;
    else meas = (targ + off > 4095) ? 4095 : targ + off;
    stall = 1'b0;
    temp_ok = 1'b1;
    if ($urandom_range(0, 99) < fault_pct) begin
      r = $urandom_range(0, 2);
      stall = (r != 1);
      temp_ok = (r == 0);
    end
    if ($urandom_range(0, 4) == 0) btn_level = ~btn_level;
    return make_tick(meas, targ, stall, temp_ok, btn_level);
  endfunction

  task automatic drive_tick(drca_pkg::drca_in_t t);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {{(drca_pkg::InDataW - $bits(drca_pkg::drca_in_t)){1'b0}}, t};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_tick(t);
  endtask

  task automatic wait_drained();
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [drca_pkg::PctW-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    sb.set_threshold(value);
    settings_used++;
  endtask

  task automatic run_random(int unsigned count);
    int unsigned done;
    int unsigned run_len;
    int unsigned fault_pct;
    int          dir;
    done = 0;
    while (done < count) begin
      dir = $urandom_range(0, 2);
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) begin
        run_len = $urandom_range(80, 150);
        fault_pct = 0;
      end else begin
        run_len = $urandom_range(5, 60);
        fault_pct = 10;
      end
      repeat (run_len) begin
        if (done < count) drive_tick(random_tick(dir, fault_pct));
        done++;
      end
    end
    quiet = 1'b0;
    s_valid <= 1'b0;
  endtask

  initial begin
    m_ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_ready) sb.check_result(m_axis_tdata_o);
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready) ||
          (cfg_valid && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= StallLimit) begin
        $display("Timeout: %0d cycles without a transaction", StallLimit);
        $display("tb_drip_rate_clamp_and_alarm_step_top NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks at the reset threshold of 30 percent.
    drive_tick(make_tick(0, 0, 0, 1, 0));
    drive_tick(make_tick(4095, 4095, 0, 1, 0));
    drive_tick(make_tick(0, 4095, 0, 1, 0));
    drive_tick(make_tick(4095, 0, 0, 1, 0));
    drive_tick(make_tick(70, 100, 0, 1, 0));
    drive_tick(make_tick(69, 100, 0, 1, 0));
    drive_tick(make_tick(131, 100, 0, 1, 0));
    drive_tick(make_tick(100, 100, 1, 1, 0));
    drive_tick(make_tick(100, 100, 0, 0, 0));
    drive_tick(make_tick(100, 100, 1, 0, 0));
    drive_tick(make_tick(200, 100, 0, 1, 0));
    drive_tick(make_tick(0, 4095, 0, 1, 1));
    drive_tick(make_tick(0, 4095, 0, 1, 1));
    drive_tick(make_tick(10, 10, 1, 1, 1));
    drive_tick(make_tick(10, 10, 0, 0, 0));
    drive_tick(make_tick(0, 4095, 0, 1, 1));
    drive_tick(make_tick(0, 4095, 0, 1, 0));
    drive_tick(make_tick(1280, 1280, 0, 1, 0));
    drive_tick(make_tick(1279, 1279, 0, 1, 0));
    drive_tick(make_tick(3263, 3263, 0, 1, 0));
    drive_tick(make_tick(3264, 3264, 0, 1, 0));
    drive_tick(make_tick(3265, 3265, 0, 1, 0));
    s_valid <= 1'b0;

    write_threshold(7'd0);
    drive_tick(make_tick(101, 100, 0, 1, 0));
    drive_tick(make_tick(100, 100, 0, 1, 0));

    run_random(250);
    write_threshold(7'd127);
    run_random(250);
    write_threshold(7'd100);
    run_random(250);
    write_threshold(7'd0);
    run_random(200);
    write_threshold(7'd1);
    run_random(200);
    repeat (4) begin
      write_threshold(7'($urandom_range(0, 127)));
      run_random(200);
    end

    wait_drained();
    $display("Covered %0d ticks over %0d threshold writes: %0d fault, %0d deviation.",
             sb.ticks, settings_used, sb.faults, sb.deviations);
    $display("Clamp reached full open %0d times; %0d alarms came while silenced.",
             sb.at_full_open, sb.silenced_alarms);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_drip_rate_clamp_and_alarm_step_top OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
      $display("tb_drip_rate_clamp_and_alarm_step_top NOT OK");
    end
    $finish;
  end

endmodule
